// ===== hw/rtl/orlr_pkg.sv =====
`default_nettype none
package orlr_pkg;

	localparam int RING_BYTES  = 1024;
	localparam int PTR_W       = $clog2(RING_BYTES);
	localparam int FILL_W      = PTR_W + 1;
	localparam int HDR_BYTES   = 20;
	localparam int HIDX_W      = $clog2(HDR_BYTES);
	localparam int MIN_PAYLOAD = 4;
	localparam int NS_PER_US   = 1000;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [FILL_W:0]   sum_t;
	typedef logic [HIDX_W-1:0] hidx_t;
	typedef logic [16:0]       tot_t;

	typedef enum logic [1:0] {
		FN_BEGIN_WR  = 2'd0,
		FN_PAYLOAD   = 2'd1,
		FN_BEGIN_RD  = 2'd2,
		FN_READ_BYTE = 2'd3
	} orlr_func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEN   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_SMALL = 3'd3,
		ST_NO_OPEN   = 3'd4,
		ST_BUSY      = 3'd5
	} orlr_status_t;

	typedef struct packed {
		orlr_func_t  func;
		logic [9:0]  payload_len;
		logic [30:0] proc_id;
		logic [30:0] time_sec;
		logic [19:0] time_usec;
		logic [7:0]  data_in;
		logic [15:0] reader_capacity;
	} orlr_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  data_out;
		logic        last;
		logic [10:0] stored_bytes;
	} orlr_rsp_t;

	typedef struct packed {
		logic [9:0]  payload_len;
		logic [30:0] proc_id;
		logic [30:0] time_sec;
		logic [31:0] nsec;
	} orlr_hdr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/orlr_if.sv =====
`default_nettype none
interface orlr_req_if;
	import orlr_pkg::*;
	logic      valid;
	logic      ready;
	orlr_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface orlr_rsp_if;
	import orlr_pkg::*;
	logic      valid;
	logic      ready;
	orlr_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/overwriting_record_log_ring_core.sv =====
// Overwriting record log ring: a byte ring of event records, each a 20-byte
// header followed by its payload. One request channel (req) carries commands
// (begin write, payload byte, begin read, read byte) and one response channel
// (rsp) returns exactly one item per command: status, popped byte, last flag
// and the fill level after the command.
// Commands are handled one at a time; req.ready is high only while the core
// is idle. A result is loaded into the rsp output register from state S_FIN.
// Begin read makes two reads of the head length through the single ring
// memory read port. Begin write: each eviction reads the head length bytes,
// and the 20 header bytes are written one per cycle through the write port.
// Rejected commands (busy, bad length, empty) go straight from idle to S_FIN.
// A stalled rsp holds its item; the core waits with the next result until
// the output register frees, and accepts nothing meanwhile.
// Reset clears pointers, fill level and open write/read counts. The ring
// memory is not cleared; only bytes already written are ever read.
`default_nettype none
module overwriting_record_log_ring_core (
	input  wire       clk,
	input  wire       arst_n,
	orlr_req_if.sink   req,
	orlr_rsp_if.source rsp
);
	import orlr_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EV_CHK = 8'b0000_0010,
		S_EV_LO  = 8'b0000_0100,
		S_EV_HI  = 8'b0000_1000,
		S_HDR    = 8'b0001_0000,
		S_BR_LO  = 8'b0010_0000,
		S_BR_HI  = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t       state_q;
	ptr_t         head_q;
	ptr_t         wp_q;
	fill_t        fill_q;
	logic [9:0]   wr_rem_q;
	fill_t        rd_rem_q;
	hidx_t        hcnt_q;
	orlr_hdr_t    hdr_q;
	logic [15:0]  cap_q;
	logic [7:0]   lo_q;
	orlr_status_t st_q;
	logic         last_q;
	logic         dsel_q;
	logic         rsp_valid_q;
	orlr_rsp_t    rsp_q;

	logic [7:0]   mem [RING_BYTES];
	logic [7:0]   rdata_q;
	logic         ren;
	ptr_t         raddr;
	logic         we;
	ptr_t         waddr;
	logic [7:0]   wdata;
	logic [7:0]   hdr_byte;

	logic         accept;
	logic         busy;
	logic         bad_len;
	logic         evict_go;
	logic         rsp_load;
	tot_t         tot;
	fill_t        clamp;

	orlr_hdr_fmt u_hdr (
		.hdr      (hdr_q),
		.idx      (hcnt_q),
		.hdr_byte (hdr_byte)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign accept   = req.valid && req.ready;
	assign busy     = (wr_rem_q != '0) || (rd_rem_q != '0);
	assign bad_len  = (int'(req.data.payload_len) < MIN_PAYLOAD) ||
		(int'(req.data.payload_len) > RING_BYTES - HDR_BYTES);
	assign evict_go = (fill_q != '0) &&
		((sum_t'(hdr_q.payload_len) + sum_t'(HDR_BYTES) + sum_t'(fill_q)) >=
		sum_t'(RING_BYTES));
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign tot      = tot_t'({rdata_q, lo_q}) + tot_t'(HDR_BYTES);
	assign clamp    = (tot > tot_t'(fill_q)) ? fill_q : fill_t'(tot);

	always_comb begin
		ren   = 1'b0;
		raddr = head_q;
		we    = 1'b0;
		waddr = wp_q;
		wdata = req.data.data_in;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.func)
						FN_PAYLOAD: we = (wr_rem_q != '0) && (fill_q < fill_t'(RING_BYTES));
						FN_READ_BYTE: ren = (rd_rem_q != '0) && (fill_q != '0);
						FN_BEGIN_RD: ren = !busy && (fill_q != '0);
						default: ren = 1'b0;
					endcase
				end
			end
			S_EV_CHK: ren = evict_go;
			S_EV_LO, S_BR_LO: begin
				ren   = 1'b1;
				raddr = head_q + ptr_t'(1);
			end
			S_HDR: begin
				we    = 1'b1;
				wdata = hdr_byte;
			end
			default: ren = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			wr_rem_q    <= '0;
			rd_rem_q    <= '0;
			hcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q    <= ST_OK;
						last_q  <= 1'b0;
						dsel_q  <= 1'b0;
						state_q <= S_FIN;
						case (req.data.func)
							FN_BEGIN_WR: begin
								if (busy) begin
									st_q <= ST_BUSY;
								end else if (bad_len) begin
									st_q <= ST_BAD_LEN;
								end else begin
									hdr_q.payload_len <= req.data.payload_len;
									hdr_q.proc_id     <= req.data.proc_id;
									hdr_q.time_sec    <= req.data.time_sec;
									hdr_q.nsec        <= {12'd0, req.data.time_usec} *
										32'(NS_PER_US);
									state_q           <= S_EV_CHK;
								end
							end
							FN_PAYLOAD: begin
								if (wr_rem_q == '0) begin
									st_q <= ST_NO_OPEN;
								end else begin
									if (fill_q < fill_t'(RING_BYTES)) begin
										wp_q   <= wp_q + ptr_t'(1);
										fill_q <= fill_q + fill_t'(1);
									end
									wr_rem_q <= wr_rem_q - 10'd1;
								end
							end
							FN_BEGIN_RD: begin
								if (busy) begin
									st_q <= ST_BUSY;
								end else if (fill_q == '0) begin
									st_q <= ST_EMPTY;
								end else begin
									cap_q   <= req.data.reader_capacity;
									state_q <= S_BR_LO;
								end
							end
							FN_READ_BYTE: begin
								if ((rd_rem_q == '0) || (fill_q == '0)) begin
									st_q     <= ST_NO_OPEN;
									rd_rem_q <= '0;
								end else begin
									head_q   <= head_q + ptr_t'(1);
									fill_q   <= fill_q - fill_t'(1);
									rd_rem_q <= rd_rem_q - fill_t'(1);
									last_q   <= (rd_rem_q == fill_t'(1));
									dsel_q   <= 1'b1;
								end
							end
							default: st_q <= ST_NO_OPEN;
						endcase
					end
				end
				S_EV_CHK: begin
					if (evict_go) begin
						state_q <= S_EV_LO;
					end else begin
						hcnt_q  <= '0;
						state_q <= S_HDR;
					end
				end
				S_EV_LO: begin
					lo_q    <= rdata_q;
					state_q <= S_EV_HI;
				end
				S_EV_HI: begin
					fill_q  <= fill_q - clamp;
					head_q  <= head_q + clamp[PTR_W-1:0];
					state_q <= S_EV_CHK;
				end
				S_HDR: begin
					wp_q   <= wp_q + ptr_t'(1);
					fill_q <= fill_q + fill_t'(1);
					hcnt_q <= hcnt_q + hidx_t'(1);
					if (hcnt_q == hidx_t'(HDR_BYTES - 1)) begin
						wr_rem_q <= hdr_q.payload_len;
						state_q  <= S_FIN;
					end
				end
				S_BR_LO: begin
					lo_q    <= rdata_q;
					state_q <= S_BR_HI;
				end
				S_BR_HI: begin
					if (tot_t'(cap_q) < tot) begin
						st_q <= ST_TOO_SMALL;
					end else begin
						rd_rem_q <= clamp;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_load) begin
						rsp_q.status       <= st_q;
						rsp_q.data_out     <= dsel_q ? rdata_q : 8'd0;
						rsp_q.last         <= last_q;
						rsp_q.stored_bytes <= fill_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fill_t'(RING_BYTES))
		else $error("fill level above ring size");

	a_no_dual_open: assert property (@(posedge clk) disable iff (!arst_n)
		!((wr_rem_q != '0) && (rd_rem_q != '0)))
		else $error("write and read open together");

	a_read_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rd_rem_q <= fill_q)
		else $error("open readout exceeds stored bytes");

	a_evict_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV_HI) |=> (fill_q < $past(fill_q)))
		else $error("eviction removed nothing");

endmodule
`default_nettype wire

// ===== hw/rtl/orlr_hdr_fmt.sv =====
`default_nettype none
module orlr_hdr_fmt (
	input  orlr_pkg::orlr_hdr_t hdr,
	input  orlr_pkg::hidx_t     idx,
	output logic [7:0]          hdr_byte
);
	import orlr_pkg::*;

	logic [HDR_BYTES*8-1:0] flat;

	// little-endian: len, hdr size, pid, tid, sec, nsec
	assign flat = {hdr.nsec, 1'b0, hdr.time_sec, 32'd0, 1'b0, hdr.proc_id,
		16'(HDR_BYTES), 6'd0, hdr.payload_len};

	assign hdr_byte = 8'(flat >> {idx, 3'b000});

endmodule
`default_nettype wire
